// ----- hdl/spc_pkg.sv -----
package spc_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int WORK_BITS   = 28;
	localparam int MAX_DEPTH   = 12;
	localparam int COORD_W     = 18;
	localparam int MAG_W       = 29;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int S_W         = 31;
	localparam int T_W         = 62;
	localparam int RAD_W       = 64;
	localparam int ROOT_W      = RAD_W / 2;
	localparam int REM_W       = ROOT_W + 3;
	localparam int W_W         = WORK_BITS + 2;
	localparam int CELL_W      = 12;
	localparam int DEPTH_W     = 4;

	localparam logic [DEPTH_W-1:0] DEPTH_RST = 4'd8;
	localparam logic [MAG_W-1:0]   WORK_ONE  = MAG_W'(1) << WORK_BITS;

	localparam logic [2:0] FACE_POS_Y = 3'd0;
	localparam logic [2:0] FACE_NEG_Y = 3'd1;
	localparam logic [2:0] FACE_POS_X = 3'd2;
	localparam logic [2:0] FACE_NEG_X = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;

	typedef struct packed {
		logic [2:0] face;
		logic       neg_a;
		logic       neg_b;
		logic       zero_a;
		logic       zero_b;
		logic       swap;
	} flags_t;

	typedef struct packed {
		logic [S_W-1:0] s;
		flags_t         f;
	} sb_t;

endpackage

// ----- hdl/sphere_point_to_cube_cell.sv -----
// Channel  Handshake            Beat
// in       in_valid / in_stall  x_coord, y_coord, z_coord (Q1.16)
// out      out_valid / out_stall face, cell_u, cell_v
// cfg      cfg_valid / cfg_ready cfg_data -> grid_depth
//
// One point per cycle unless a held out beat stalls the pipe.
// The path runs through two 32-stage square-root pipelines in series
// plus nine arithmetic stages. Reset sets grid_depth to 8 and clears
// all valid bits. A held out beat freezes the whole pipe; in_stall
// is raised for exactly those cycles.
module sphere_point_to_cube_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [spc_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [spc_pkg::COORD_W-1:0]  y_coord,
	input  logic signed [spc_pkg::COORD_W-1:0]  z_coord,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          face,
	output logic [spc_pkg::CELL_W-1:0]          cell_u,
	output logic [spc_pkg::CELL_W-1:0]          cell_v,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [spc_pkg::DEPTH_W-1:0]         cfg_data
);
	import spc_pkg::*;

	logic               en;
	logic [DEPTH_W-1:0] grid_depth_q;

	logic               v_d;
	logic [RAD_W-1:0]   d_rad;
	sb_t                sb_d, sb_q, sb_r;
	logic               v_qr;
	logic [ROOT_W-1:0]  q_root;

	logic               v_s7;
	logic [RAD_W-1:0]   r1_s7, r2_s7;
	sb_t                sb_s7;
	logic [S_W-1:0]     r1_c, r2_c;
	logic [S_W:0]       sq_sum;

	logic               v_p;
	logic [ROOT_W-1:0]  pa, pb;

	localparam logic [S_W:0] SIX = (S_W+1)'(6) << WORK_BITS;

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_depth_q <= DEPTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			grid_depth_q <= cfg_data;
		end
	end

	spc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (in_valid),
		.x_in   (x_coord),
		.y_in   (y_coord),
		.z_in   (z_coord),
		.v_out  (v_d),
		.d_out  (d_rad),
		.sb_out (sb_d)
	);

	spc_sqrt u_sqrt_d (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_d),
		.rad_in   (d_rad),
		.sb_in    (sb_d),
		.v_out    (v_qr),
		.root_out (q_root),
		.sb_out   (sb_q)
	);

	// r1 = s - q, r2 = 6 - s - q floored at zero
	assign sq_sum = (S_W+1)'(sb_q.s) + (S_W+1)'(q_root[S_W-1:0]);
	assign r1_c   = sb_q.s - q_root[S_W-1:0];
	assign r2_c   = (SIX > sq_sum) ? S_W'(SIX - sq_sum) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_qr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r1_s7 <= RAD_W'(r1_c) << (WORK_BITS - 1);
			r2_s7 <= RAD_W'(r2_c) << (WORK_BITS - 1);
			sb_s7 <= '{s: '0, f: sb_q.f};
		end
	end

	spc_sqrt u_sqrt_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s7),
		.rad_in   (r1_s7),
		.sb_in    (sb_s7),
		.v_out    (v_p),
		.root_out (pa),
		.sb_out   (sb_r)
	);

	spc_sqrt u_sqrt_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s7),
		.rad_in   (r2_s7),
		.sb_in    (sb_s7),
		.v_out    (),
		.root_out (pb),
		.sb_out   ()
	);

	spc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.v_in       (v_p),
		.pa_in      (pa),
		.pb_in      (pb),
		.f_in       (sb_r.f),
		.depth      (grid_depth_q),
		.v_out      (out_valid),
		.face_out   (face),
		.u_out      (cell_u),
		.v_cell_out (cell_v)
	);

endmodule

// ----- hdl/spc_sqrt.sv -----
module spc_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      v_in,
	input  logic [spc_pkg::RAD_W-1:0] rad_in,
	input  spc_pkg::sb_t              sb_in,
	output logic                      v_out,
	output logic [spc_pkg::ROOT_W-1:0] root_out,
	output spc_pkg::sb_t              sb_out
);
	import spc_pkg::*;

	logic              v_s    [0:ROOT_W];
	logic [RAD_W-1:0]  rad_s  [0:ROOT_W];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	sb_t               sb_s   [0:ROOT_W];

	assign v_s[0]    = v_in;
	assign rad_s[0]  = rad_in;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign sb_s[0]   = sb_in;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		logic             ge;

		assign cur   = {rem_s[k][REM_W-3:0], rad_s[k][RAD_W-1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][RAD_W-3:0], 2'b00};
				rem_s[k+1]  <= ge ? (cur - trial) : cur;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
				sb_s[k+1]   <= sb_s[k];
			end
		end
	end

	assign v_out    = v_s[ROOT_W];
	assign root_out = root_s[ROOT_W];
	assign sb_out   = sb_s[ROOT_W];

endmodule

// ----- hdl/spc_front.sv -----
module spc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  logic signed [spc_pkg::COORD_W-1:0] x_in,
	input  logic signed [spc_pkg::COORD_W-1:0] y_in,
	input  logic signed [spc_pkg::COORD_W-1:0] z_in,
	output logic                        v_out,
	output logic [spc_pkg::RAD_W-1:0]   d_out,
	output spc_pkg::sb_t                sb_out
);
	import spc_pkg::*;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	logic [MAG_W-1:0]          a_s2, b_s2;
	flags_t                    f_s2, f_s3, f_s4, f_s5;
	sb_t                       sb_s6;
	logic [SQ_W-1:0]           asq_s3, bsq_s3;
	logic [S_W-1:0]            s_s4, s_s5;
	logic [T_W-1:0]            t_s4, t_s5, ss_s5;
	logic [RAD_W-1:0]          d_s6;

	logic [COORD_W-1:0]        mx, my, mz;
	logic signed [COORD_W-1:0] ra, rb;
	logic [MAG_W-1:0]          wa, wb;
	flags_t                    f_c;
	logic [SQ_W+1:0]           sum56;
	logic [T_W-1:0]            t_c;

	function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] v);
		mag = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
	endfunction

	function automatic logic [MAG_W-1:0] to_work(input logic signed [COORD_W-1:0] v);
		logic [W_W-1:0] m;
		m = {mag(v), (WORK_BITS - FRAC_BITS)'(0)};
		to_work = (m > W_W'(WORK_ONE)) ? WORK_ONE : m[MAG_W-1:0];
	endfunction

	always_comb begin
		mx = mag(x_s1);
		my = mag(y_s1);
		mz = mag(z_s1);
		f_c = '0;
		if (my >= mx && my >= mz) begin
			ra = x_s1;
			rb = z_s1;
			f_c.face = (y_s1 > 0) ? FACE_POS_Y : FACE_NEG_Y;
		end else if (mx >= my && mx >= mz) begin
			ra = y_s1;
			rb = z_s1;
			f_c.face = (x_s1 > 0) ? FACE_POS_X : FACE_NEG_X;
		end else begin
			ra = x_s1;
			rb = y_s1;
			f_c.face = (z_s1 > 0) ? FACE_POS_Z : FACE_NEG_Z;
			f_c.swap = 1'b1;
		end
		f_c.neg_a  = ra[COORD_W-1];
		f_c.neg_b  = rb[COORD_W-1];
		f_c.zero_a = (ra == '0);
		f_c.zero_b = (rb == '0);
		wa = to_work(ra);
		wb = to_work(rb);
	end

	// s = 2A^2 - 2B^2 + 3, all at 56 fraction bits
	assign sum56 = {1'b0, asq_s3, 1'b0} + ((SQ_W+2)'(3) << (2 * WORK_BITS))
		- {1'b0, bsq_s3, 1'b0};
	assign t_c   = (T_W'(asq_s3) << 4) + (T_W'(asq_s3) << 3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_in;
			y_s1   <= y_in;
			z_s1   <= z_in;
			a_s2   <= wa;
			b_s2   <= wb;
			f_s2   <= f_c;
			asq_s3 <= a_s2 * a_s2;
			bsq_s3 <= b_s2 * b_s2;
			f_s3   <= f_s2;
			s_s4   <= sum56[WORK_BITS +: S_W];
			t_s4   <= t_c;
			f_s4   <= f_s3;
			ss_s5  <= s_s4 * s_s4;
			s_s5   <= s_s4;
			t_s5   <= t_s4;
			f_s5   <= f_s4;
			d_s6   <= (ss_s5 > t_s5) ? RAD_W'(ss_s5 - t_s5) : '0;
			sb_s6  <= '{s: s_s5, f: f_s5};
		end
	end

	assign v_out  = v_s6;
	assign d_out  = d_s6;
	assign sb_out = sb_s6;

endmodule

// ----- hdl/spc_back.sv -----
module spc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_in,
	input  logic [spc_pkg::ROOT_W-1:0]    pa_in,
	input  logic [spc_pkg::ROOT_W-1:0]    pb_in,
	input  spc_pkg::flags_t               f_in,
	input  logic [spc_pkg::DEPTH_W-1:0]   depth,
	output logic                          v_out,
	output logic [2:0]                    face_out,
	output logic [spc_pkg::CELL_W-1:0]    u_out,
	output logic [spc_pkg::CELL_W-1:0]    v_cell_out
);
	import spc_pkg::*;

	logic             v_s8, v_q;
	logic [W_W-1:0]   wu_s8, wv_s8;
	logic [2:0]       face_s8, face_q;
	logic [CELL_W-1:0] u_q, vc_q;

	logic [W_W-1:0]   wa, wb;
	logic [DEPTH_W-1:0] dc;

	function automatic logic [W_W-1:0] finish(input logic [ROOT_W-1:0] p,
		input logic neg, input logic zero);
		logic [MAG_W-1:0] pc;
		pc = (p > ROOT_W'(WORK_ONE)) ? WORK_ONE : p[MAG_W-1:0];
		if (zero)
			finish = W_W'(WORK_ONE);
		else if (neg)
			finish = W_W'(WORK_ONE) - W_W'(pc);
		else
			finish = W_W'(WORK_ONE) + W_W'(pc);
	endfunction

	function automatic logic [CELL_W-1:0] to_cell(input logic [W_W-1:0] w,
		input logic [DEPTH_W-1:0] d);
		logic [W_W-1:0]    c;
		logic [CELL_W:0]   size;
		c    = w >> (W_W'(WORK_BITS + 1) - W_W'(d));
		size = (CELL_W+1)'(1) << d;
		to_cell = (c >= W_W'(size)) ? CELL_W'(size - 1'b1) : c[CELL_W-1:0];
	endfunction

	assign wa = finish(pa_in, f_in.neg_a, f_in.zero_a);
	assign wb = finish(pb_in, f_in.neg_b, f_in.zero_b);
	assign dc = (depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : depth;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s8 <= v_in;
			v_q  <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wu_s8   <= f_in.swap ? wb : wa;
			wv_s8   <= f_in.swap ? wa : wb;
			face_s8 <= f_in.face;
			face_q  <= face_s8;
			u_q     <= to_cell(wu_s8, dc);
			vc_q    <= to_cell(wv_s8, dc);
		end
	end

	assign v_out      = v_q;
	assign face_out   = face_q;
	assign u_out      = u_q;
	assign v_cell_out = vc_q;

endmodule

// ----- hdl/spc_checker.sv -----
module spc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [17:0] x_coord,
	input logic [17:0] y_coord,
	input logic [17:0] z_coord,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  face,
	input logic [11:0] cell_u,
	input logic [11:0] cell_v,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [3:0]  cfg_data
);

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow a held out beat");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (face != 3'd6 && face != 3'd7))
		else $error("face code out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(face)
			&& $stable(cell_u) && $stable(cell_v))
		else $error("held out beat changed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write refused");

endmodule

bind sphere_point_to_cube_cell spc_checker u_spc_checker (.*);
